// File: rtl/counting_sort_histogram_unit_macros.svh
// assertion helpers for counting_sort_histogram_unit
`ifndef COUNTING_SORT_HISTOGRAM_UNIT_MACROS_SVH
`define COUNTING_SORT_HISTOGRAM_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CSH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CSH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/csh_pkg.sv
`timescale 1ns / 1ps
package csh_pkg;

  // fixed field widths
  localparam int VALUE_W = 10;
  // wide enough to compare any value against any supported range
  localparam int EXT_W   = 17;

  // parameter defaults
  localparam int VALUE_RANGE_DEF = 1024;
  localparam int MAX_HELD_DEF    = 1024;

  // function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

endpackage

// File: rtl/csh_ram.sv
`timescale 1ns / 1ps
module csh_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/counting_sort_histogram_unit.sv
`timescale 1ns / 1ps
// load word: bin read, then bin write back; busy during the write back
// pull word: examines bins from the scan pointer up to the first non-empty bin,
//   one bin per cycle through the registered ram read; a pull on empty needs no scan
// result strobe follows the last busy cycle, or the accept of an empty pull; no stall
// reset: synchronous, active low; afterwards a clearing pass walks bins 0 to VALUE_RANGE-1
//   and writes every bin to zero while busy is high
module counting_sort_histogram_unit
  #(
  parameter int VALUE_RANGE = csh_pkg::VALUE_RANGE_DEF,
  parameter int MAX_HELD    = csh_pkg::MAX_HELD_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [csh_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  output logic [csh_pkg::VALUE_W-1:0] out_sorted_value,
  output logic                        out_last_item,
  output logic                        out_was_empty,
  output logic                        out_dropped_any
);
  import csh_pkg::*;
  `include "counting_sort_histogram_unit_macros.svh"

  localparam int AW = $clog2(VALUE_RANGE);
  localparam int CW = $clog2(MAX_HELD + 1);
  localparam logic [AW-1:0] LAST_BIN = AW'(VALUE_RANGE - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_HELD);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_WR,
    ST_SCAN
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic          drop_r, drop_nxt;
  logic [AW-1:0] ld_addr_r, ld_addr_nxt;
  logic [AW-1:0] chk_r, chk_nxt;
  logic [AW-1:0] iss_r, iss_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]   out_value_r, out_value_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic                 out_drop_r, out_drop_nxt;

  logic             accept;
  logic [EXT_W-1:0] val_ext;
  logic [EXT_W-1:0] chk_ext;
  logic             in_rng;
  logic [AW-1:0]    in_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CW-1:0]    mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [CW-1:0]    mem_rdata;
  logic             bin_hit;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign val_ext = EXT_W'(in_value);
  assign chk_ext = EXT_W'(chk_r);
  assign in_rng  = (val_ext < EXT_W'(VALUE_RANGE));
  assign in_addr = val_ext[AW-1:0];
  assign bin_hit = (mem_rdata != '0);

  // bin count store
  csh_ram #(
    .WIDTH(CW),
    .DEPTH(VALUE_RANGE)
  ) u_bins (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // read address: when idle, a load's bin or the scan pointer for a pull; the next scan bin otherwise
  always_comb begin
    if (state_r == ST_IDLE) begin
      mem_raddr = (in_func == FUNC_PULL) ? scan_r : in_addr;
    end else begin
      mem_raddr = iss_r;
    end
  end

  // write back: clear sweep, load increment, pull decrement
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_LD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ld_addr_r;
        mem_wdata = mem_rdata + CW'(1);
      end
      ST_SCAN: begin
        mem_we    = bin_hit;
        mem_waddr = chk_r;
        mem_wdata = mem_rdata - CW'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    held_nxt      = held_r;
    scan_nxt      = scan_r;
    drop_nxt      = drop_r;
    ld_addr_nxt   = ld_addr_r;
    chk_nxt       = chk_r;
    iss_nxt       = iss_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_drop_nxt  = out_drop_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_BIN) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_LOAD) begin
            if (!in_rng || held_r >= FULL_CNT) begin
              drop_nxt = 1'b1;
            end else begin
              ld_addr_nxt = in_addr;
              held_nxt    = held_r + CW'(1);
              if (in_addr < scan_r) begin
                scan_nxt = in_addr;
              end
              state_nxt = ST_LD_WR;
            end
          end else if (held_r == '0) begin
            // pull on empty answers at once
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_last_nxt  = 1'b0;
            out_empty_nxt = 1'b1;
            out_drop_nxt  = drop_r;
          end else begin
            chk_nxt   = scan_r;
            iss_nxt   = scan_r + AW'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LD_WR: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (bin_hit) begin
          held_nxt      = held_r - CW'(1);
          scan_nxt      = chk_r;
          out_valid_nxt = 1'b1;
          out_value_nxt = chk_ext[VALUE_W-1:0];
          out_last_nxt  = (held_r == CW'(1));
          out_empty_nxt = 1'b0;
          out_drop_nxt  = drop_r;
          state_nxt     = ST_IDLE;
        end else if (chk_r == LAST_BIN) begin
          // counts inconsistent: nothing found, treat as empty
          held_nxt      = '0;
          scan_nxt      = '0;
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_last_nxt  = 1'b0;
          out_empty_nxt = 1'b1;
          out_drop_nxt  = drop_r;
          state_nxt     = ST_IDLE;
        end else begin
          chk_nxt = iss_r;
          iss_nxt = iss_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      held_r      <= '0;
      scan_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      held_r      <= held_nxt;
      scan_r      <= scan_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ld_addr_r   <= ld_addr_nxt;
    chk_r       <= chk_nxt;
    iss_r       <= iss_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_item    = out_last_r;
  assign out_was_empty    = out_empty_r;
  assign out_dropped_any  = out_drop_r;

  // checks
  `CSH_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE, "result word while busy")
  `CSH_ASSERT_IMP(a_held_bound, clk, rst_n, 1'b1, held_r <= FULL_CNT, "held count above limit")
  `CSH_ASSERT_IMP(a_empty_word, clk, rst_n, out_valid_r && out_empty_r, (out_value_r == '0) && !out_last_r, "empty result carries data")
  `CSH_ASSERT_NXT(a_load_wb, clk, rst_n, accept && (in_func == FUNC_LOAD) && in_rng && (held_r < FULL_CNT), state_r == ST_LD_WR, "load word skipped write back")
  `CSH_ASSERT_NXT(a_drop_sticky, clk, rst_n, drop_r, drop_r, "drop flag cleared")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import csh_pkg::*;

  localparam int HIST_RANGE  = VALUE_RANGE_DEF;
  localparam int HIST_DEPTH  = MAX_HELD_DEF;
  localparam int PHASE_WORDS = 233;
  localparam int CNT_W       = 11;

  // one pending word for the driver; pause marks a wait for all pulls to answer
  typedef struct {
    logic               op;
    logic [VALUE_W-1:0] val;
    bit                 pause;
    int unsigned        gap_pct;
  } word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic               last_item;
    logic               was_empty;
    logic               dropped_any;
  } pull_res_t;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               start    = 1'b0;
  logic               in_func  = FUNC_LOAD;
  logic [VALUE_W-1:0] in_value = '0;
  logic               busy;
  logic               out_valid;
  logic [VALUE_W-1:0] out_sorted_value;
  logic               out_last_item;
  logic               out_was_empty;
  logic               out_dropped_any;

  counting_sort_histogram_unit #(
    .VALUE_RANGE(HIST_RANGE),
    .MAX_HELD   (HIST_DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_sorted_value(out_sorted_value),
    .out_last_item   (out_last_item),
    .out_was_empty   (out_was_empty),
    .out_dropped_any (out_dropped_any)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // histogram mirror
  logic [CNT_W-1:0] bin_cnt [HIST_RANGE];
  logic [CNT_W-1:0] held;
  int               scan_pos;
  logic             drop_seen;

  pull_res_t   sorted_q [$];
  word_t       word_q [$];
  int unsigned pulls_acc    = 0;
  int unsigned results_seen = 0;
  int unsigned words_acc    = 0;
  int unsigned total_words  = 0;
  int unsigned n_loads      = 0;
  int unsigned n_drops      = 0;
  int unsigned n_pulls      = 0;
  int unsigned n_empty      = 0;
  int unsigned n_pauses     = 0;
  int          errors       = 0;

  // stimulus builder state: count held as the generator sees it
  int unsigned gen_held    = 0;
  int unsigned gen_gap     = 0;
  int unsigned phase_words = 0;

  function void hist_clear();
    for (int i = 0; i < HIST_RANGE; i++) bin_cnt[i] = '0;
    held      = '0;
    scan_pos  = 0;
    drop_seen = 1'b0;
  endfunction

  // apply one accepted word to the mirror, queue the expected pull result
  task hist_step(input logic op, input logic [VALUE_W-1:0] v);
    pull_res_t r;
    int        p;
    if (op == FUNC_LOAD) begin
      n_loads++;
      if (int'(v) >= HIST_RANGE || held >= HIST_DEPTH) begin
        drop_seen = 1'b1;
        n_drops++;
      end else begin
        bin_cnt[v]++;
        held++;
        if (int'(v) < scan_pos) scan_pos = int'(v);
      end
    end else begin
      n_pulls++;
      r             = '0;
      r.dropped_any = drop_seen;
      p             = scan_pos;
      if (held != 0) begin
        while (p < HIST_RANGE && bin_cnt[p] == 0) p++;
      end
      if (held == 0 || p >= HIST_RANGE) begin
        // nothing held: flag it, state untouched unless the counts disagree
        r.was_empty = 1'b1;
        n_empty++;
        if (held != 0) begin
          held     = '0;
          scan_pos = 0;
        end
      end else begin
        bin_cnt[p]--;
        held--;
        scan_pos       = p;
        r.sorted_value = p[VALUE_W-1:0];
        r.last_item    = (held == 0);
      end
      sorted_q.push_back(r);
    end
  endtask

  function void add_word(input logic op, input logic [VALUE_W-1:0] v);
    word_t w;
    w.op      = op;
    w.val     = v;
    w.pause   = 1'b0;
    w.gap_pct = gen_gap;
    word_q.push_back(w);
    total_words++;
    phase_words++;
    if (op == FUNC_LOAD) begin
      if (gen_held < HIST_DEPTH) gen_held++;
    end else if (gen_held > 0) begin
      gen_held--;
    end
  endfunction

  function void add_pull();
    add_word(FUNC_PULL, VALUE_W'($urandom_range(HIST_RANGE - 1, 0)));
  endfunction

  function void add_pause();
    word_t w;
    w.op      = FUNC_LOAD;
    w.val     = '0;
    w.pause   = 1'b1;
    w.gap_pct = 0;
    word_q.push_back(w);
    n_pauses++;
  endfunction

  // pull everything still held
  function void add_drain();
    int n;
    n = gen_held;
    for (int i = 0; i < n; i++) add_pull();
  endfunction

  // one random batch: mostly load-then-drain runs, some raw noise
  function void add_batch();
    int          n;
    int          span;
    int          base;
    int          k;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 78) begin
      n    = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(12, 1);
      span = ($urandom_range(7) == 0) ? HIST_RANGE - 1 : $urandom_range(63, 0);
      base = $urandom_range(HIST_RANGE - 1 - span, 0);
      for (int i = 0; i < n; i++) add_word(FUNC_LOAD, VALUE_W'(base + $urandom_range(span, 0)));
      if (kind < 25) begin
        // partial drain, then loads that may fall below the scan point
        k = gen_held / 2;
        for (int i = 0; i < k; i++) add_pull();
        for (int i = 0; i <= n / 2; i++) begin
          add_word(FUNC_LOAD, VALUE_W'($urandom_range(base + span, 0)));
        end
      end
      add_drain();
      if ($urandom_range(4) == 0) add_pull();
    end else begin
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
        add_word($urandom_range(1) ? FUNC_PULL : FUNC_LOAD,
                 VALUE_W'($urandom_range(HIST_RANGE - 1, 0)));
      end
    end
    if ($urandom_range(11) == 0) add_pause();
  endfunction

  function void check_field(input string name, input logic [VALUE_W-1:0] want,
                            input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // driver: present the next word once the current one is taken
  always @(posedge clk) begin : drv
    logic        took;
    int unsigned owed;
    word_t       w;
    if (!rst_n) begin
      start <= 1'b0;
      hist_clear();
    end else begin
      took = start && !busy;
      if (took) begin
        hist_step(in_func, in_value);
        words_acc <= words_acc + 1;
      end
      owed = pulls_acc - results_seen;
      if (took && in_func == FUNC_PULL) begin
        pulls_acc <= pulls_acc + 1;
        owed++;
      end
      if (!start || took) begin
        if (word_q.size() != 0 && word_q[0].pause) begin
          if (owed == 0) void'(word_q.pop_front());
          start <= 1'b0;
        end else if (word_q.size() != 0 && $urandom_range(99) >= word_q[0].gap_pct) begin
          w = word_q.pop_front();
          start    <= 1'b1;
          in_func  <= w.op;
          in_value <= w.val;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each strobed word against the oldest expected pull result
  always @(posedge clk) begin : mon
    pull_res_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (results_seen == pulls_acc) begin
        errors++;
        $display("%0t: result word with no pull pending, expected none, got value %0d",
                 $time, out_sorted_value);
      end else begin
        e = sorted_q.pop_front();
        results_seen <= results_seen + 1;
        check_field("sorted_value", e.sorted_value, out_sorted_value);
        check_field("last_item", VALUE_W'(e.last_item), VALUE_W'(out_last_item));
        check_field("was_empty", VALUE_W'(e.was_empty), VALUE_W'(out_was_empty));
        check_field("dropped_any", VALUE_W'(e.dropped_any), VALUE_W'(out_dropped_any));
      end
    end
  end

  // stimulus build, reset, and end of run
  initial begin : run
    // directed: empty pull, bit patterns, duplicates, scan pointer moving down
    gen_gap = 33;
    add_pull();
    add_word(FUNC_LOAD, 10'd1023);
    add_word(FUNC_LOAD, 10'd0);
    add_word(FUNC_LOAD, 10'd0);
    add_word(FUNC_LOAD, 10'b1000000000);
    add_word(FUNC_LOAD, 10'b0101010101);
    add_word(FUNC_LOAD, 10'b1010101010);
    repeat (6) add_pull();
    add_pull();
    add_word(FUNC_LOAD, 10'd5);
    add_pull();
    add_word(FUNC_LOAD, 10'd3);
    add_word(FUNC_LOAD, 10'd7);
    add_pull();
    add_word(FUNC_LOAD, 10'd1);
    add_pull();
    add_pull();

    // phase one: sender idles about a third of the time
    phase_words = 0;
    while (phase_words < PHASE_WORDS) add_batch();
    add_pause();

    // phase two: sender idles often; starts with a lone top bin and an empty pull
    gen_gap = 72;
    add_drain();
    add_word(FUNC_LOAD, 10'd1023);
    add_drain();
    add_pull();
    add_pause();
    phase_words = 0;
    while (phase_words < PHASE_WORDS) add_batch();
    add_pause();

    // phase three: back to back
    gen_gap     = 0;
    phase_words = 0;
    while (phase_words < PHASE_WORDS) add_batch();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (!(words_acc == total_words && pulls_acc == results_seen)) @(posedge clk);
    repeat (HIST_RANGE + 16) @(posedge clk);

    if (sorted_q.size() != 0) begin
      errors++;
      $display("%0t: pull results never arrived, expected %0d more, got 0",
               $time, sorted_q.size());
    end
    $display("covered %0d loads (%0d dropped on a full store) and %0d pulls (%0d empty)",
             n_loads, n_drops, n_pulls, n_empty);
    $display("three sender pacing phases, %0d pauses for the histogram to answer", n_pauses);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #200_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
